// File: hdl/json_string_unescape_utf8_defines.svh
// ---------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared concurrent check forms for the decoder top level.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication, disabled in reset
`define JSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu: same-cycle check failed");

// next-cycle implication, disabled in reset
`define JSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu: next-cycle check failed");

`endif

// File: hdl/jsu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON string unescape package
// Types, codes and the UTF-8 encoder shared by the decoder modules.
// ---------------------------------------------------------------------------
package jsu_pkg;

    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int MAX_RESULTS      = 4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NO_QUOTE  = 4'd1,
        ERR_CTRL      = 4'd2,
        ERR_OPEN_ESC  = 4'd3,
        ERR_SHORT_HEX = 4'd4,
        ERR_BAD_HEX   = 4'd5,
        ERR_MISS_LO   = 4'd6,
        ERR_LONE_LO   = 4'd7,
        ERR_BAD_ESC   = 4'd8,
        ERR_UNTERM    = 4'd9
    } t_err;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_BODY   = 7'b0000010,
        PH_ESC    = 7'b0000100,
        PH_HEX_HI = 7'b0001000,
        PH_BSL    = 7'b0010000,
        PH_U      = 7'b0100000,
        PH_HEX_LO = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [2:0]                   cnt;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } t_utf8;

    typedef struct packed {
        logic [2:0]                   cnt;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        t_status                      status;
        t_err                         code;
    } t_dec_res;

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r.bytes = '0;
        if (cp[20:7] == 14'd0) begin
            r.cnt      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp[20:11] == 10'd0) begin
            r.cnt      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp[20:16] == 5'd0) begin
            r.cnt      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.cnt      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// File: hdl/jsu_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON string unescape decode stage
// Phase register, hex collection and surrogate joining; produces the results
// of one accepted beat.
// ---------------------------------------------------------------------------
module jsu_decode #(
    parameter int OFFSET_WIDTH = jsu_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_in_byte,
    input  logic                     i_text_end,
    output jsu_pkg::t_dec_res        o_res,
    output logic [OFFSET_WIDTH-1:0]  o_error_offset
);

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam logic [OFFSET_WIDTH-1:0] OFF_ONE = OFFSET_WIDTH'(1);

    jsu_pkg::t_phase           r_phase, n_phase;
    logic [15:0]               r_hex_acc, n_hex_acc;
    logic [9:0]                r_saved_hi, n_saved_hi;
    logic [OFFSET_WIDTH-1:0]   r_pos, n_pos;
    logic [1:0]                r_hex_cnt, n_hex_cnt;
    logic [OFFSET_WIDTH-1:0]   r_hex_start, n_hex_start;

    logic [3:0]                hex_d;
    logic                      hex_ok;
    logic [15:0]               acc_next;
    logic [20:0]               cp;
    jsu_pkg::t_utf8            enc;
    logic [OFFSET_WIDTH-1:0]   pos_inc;
    logic                      err;
    jsu_pkg::t_err             err_code;
    logic [OFFSET_WIDTH-1:0]   err_off;
    logic                      to_idle;

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            hex_d = i_in_byte[3:0];
        end else if (i_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hex_d = i_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_next = {r_hex_acc[11:0], hex_d};
    assign pos_inc  = (r_pos == OFF_MAX) ? r_pos : r_pos + OFF_ONE;
    assign cp       = (r_phase == jsu_pkg::PH_HEX_LO)
                    ? 21'h10000 + {1'b0, r_saved_hi, acc_next[9:0]}
                    : {5'd0, acc_next};
    assign enc      = jsu_pkg::utf8_encode(cp);

    always_comb begin
        n_phase      = r_phase;
        n_hex_acc    = r_hex_acc;
        n_saved_hi   = r_saved_hi;
        n_pos        = r_pos;
        n_hex_cnt    = r_hex_cnt;
        n_hex_start  = r_hex_start;
        o_res.cnt    = 3'd0;
        o_res.bytes  = '0;
        o_res.status = jsu_pkg::ST_DATA;
        o_res.code   = jsu_pkg::ERR_NONE;
        o_error_offset = '0;
        err      = 1'b0;
        err_code = jsu_pkg::ERR_NONE;
        err_off  = '0;
        to_idle  = 1'b0;
        if (i_accept) begin
            case (r_phase)
                jsu_pkg::PH_BODY: begin
                    if (i_text_end) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_UNTERM; err_off = r_pos;
                    end else begin
                        n_pos = pos_inc;
                        if (i_in_byte == jsu_pkg::CH_QUOTE) begin
                            o_res.cnt    = 3'd1;
                            o_res.status = jsu_pkg::ST_DONE;
                            to_idle      = 1'b1;
                        end else if (i_in_byte < jsu_pkg::CH_SPACE) begin
                            err = 1'b1; err_code = jsu_pkg::ERR_CTRL; err_off = r_pos;
                        end else if (i_in_byte == jsu_pkg::CH_BSL) begin
                            n_phase = jsu_pkg::PH_ESC;
                        end else begin
                            o_res.cnt      = 3'd1;
                            o_res.bytes[0] = i_in_byte;
                        end
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (i_text_end) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_OPEN_ESC; err_off = r_pos;
                    end else begin
                        n_pos   = pos_inc;
                        n_phase = jsu_pkg::PH_BODY;
                        o_res.cnt = 3'd1;
                        case (i_in_byte)
                            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: begin
                                o_res.bytes[0] = i_in_byte;
                            end
                            jsu_pkg::CH_B: o_res.bytes[0] = 8'h08;
                            jsu_pkg::CH_F: o_res.bytes[0] = 8'h0C;
                            jsu_pkg::CH_N: o_res.bytes[0] = 8'h0A;
                            jsu_pkg::CH_R: o_res.bytes[0] = 8'h0D;
                            jsu_pkg::CH_T: o_res.bytes[0] = 8'h09;
                            jsu_pkg::CH_U: begin
                                o_res.cnt   = 3'd0;
                                n_phase     = jsu_pkg::PH_HEX_HI;
                                n_hex_acc   = 16'd0;
                                n_hex_cnt   = 2'd0;
                                n_hex_start = pos_inc;
                            end
                            default: begin
                                o_res.cnt = 3'd0;
                                err = 1'b1; err_code = jsu_pkg::ERR_BAD_ESC; err_off = r_pos;
                            end
                        endcase
                    end
                end
                jsu_pkg::PH_HEX_HI, jsu_pkg::PH_HEX_LO: begin
                    if (i_text_end) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_SHORT_HEX;
                        err_off = r_hex_start;
                    end else if (!hex_ok) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_BAD_HEX; err_off = r_pos;
                    end else begin
                        n_pos     = pos_inc;
                        n_hex_acc = acc_next;
                        if (r_hex_cnt != 2'd3) begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = 2'd0;
                            if (r_phase == jsu_pkg::PH_HEX_HI) begin
                                if (acc_next inside {[16'hD800:16'hDBFF]}) begin
                                    n_saved_hi = acc_next[9:0];
                                    n_phase    = jsu_pkg::PH_BSL;
                                end else if (acc_next inside {[16'hDC00:16'hDFFF]}) begin
                                    err = 1'b1; err_code = jsu_pkg::ERR_LONE_LO;
                                    err_off = r_hex_start;
                                end else begin
                                    n_phase     = jsu_pkg::PH_BODY;
                                    o_res.cnt   = enc.cnt;
                                    o_res.bytes = enc.bytes;
                                end
                            end else begin
                                if (acc_next inside {[16'hDC00:16'hDFFF]}) begin
                                    n_phase     = jsu_pkg::PH_BODY;
                                    o_res.cnt   = enc.cnt;
                                    o_res.bytes = enc.bytes;
                                end else begin
                                    err = 1'b1; err_code = jsu_pkg::ERR_MISS_LO;
                                    err_off = r_hex_start;
                                end
                            end
                        end
                    end
                end
                jsu_pkg::PH_BSL: begin
                    if (i_text_end || i_in_byte != jsu_pkg::CH_BSL) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_MISS_LO; err_off = r_pos;
                    end else begin
                        n_hex_start = r_pos;
                        n_pos       = pos_inc;
                        n_phase     = jsu_pkg::PH_U;
                    end
                end
                jsu_pkg::PH_U: begin
                    if (i_text_end || i_in_byte != jsu_pkg::CH_U) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_MISS_LO;
                        err_off = r_hex_start;
                    end else begin
                        n_pos       = pos_inc;
                        n_phase     = jsu_pkg::PH_HEX_LO;
                        n_hex_acc   = 16'd0;
                        n_hex_cnt   = 2'd0;
                        n_hex_start = pos_inc;
                    end
                end
                default: begin
                    if (i_text_end || i_in_byte != jsu_pkg::CH_QUOTE) begin
                        err = 1'b1; err_code = jsu_pkg::ERR_NO_QUOTE; err_off = '0;
                    end else begin
                        n_phase     = jsu_pkg::PH_BODY;
                        n_hex_acc   = 16'd0;
                        n_saved_hi  = 10'd0;
                        n_pos       = OFF_ONE;
                        n_hex_cnt   = 2'd0;
                        n_hex_start = '0;
                    end
                end
            endcase
            if (err) begin
                o_res.cnt      = 3'd1;
                o_res.bytes    = '0;
                o_res.status   = jsu_pkg::ST_ERROR;
                o_res.code     = err_code;
                o_error_offset = err_off;
                to_idle        = 1'b1;
            end
            if (to_idle) begin
                n_phase     = jsu_pkg::PH_IDLE;
                n_hex_acc   = 16'd0;
                n_saved_hi  = 10'd0;
                n_pos       = '0;
                n_hex_cnt   = 2'd0;
                n_hex_start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jsu_pkg::PH_IDLE;
            r_hex_acc   <= 16'd0;
            r_saved_hi  <= 10'd0;
            r_pos       <= '0;
            r_hex_cnt   <= 2'd0;
            r_hex_start <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hex_acc   <= n_hex_acc;
            r_saved_hi  <= n_saved_hi;
            r_pos       <= n_pos;
            r_hex_cnt   <= n_hex_cnt;
            r_hex_start <= n_hex_start;
        end
    end

endmodule

// File: hdl/jsu_outbuf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON string unescape result buffer
// Holds the up to four results of one beat and hands them out in order.
// ---------------------------------------------------------------------------
module jsu_outbuf #(
    parameter int OFFSET_WIDTH = jsu_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  jsu_pkg::t_dec_res        i_res,
    input  logic [OFFSET_WIDTH-1:0]  i_error_offset,
    input  logic                     i_m_ready,
    output logic                     o_load_ready,
    output logic                     o_valid,
    output logic                     o_last,
    output logic [7:0]               o_byte,
    output jsu_pkg::t_status         o_status,
    output jsu_pkg::t_err            o_code,
    output logic [OFFSET_WIDTH-1:0]  o_offset
);

    logic [2:0]                              r_cnt;
    logic [jsu_pkg::MAX_RESULTS-1:0][7:0]    r_bytes;
    jsu_pkg::t_status                        r_status;
    jsu_pkg::t_err                           r_code;
    logic [OFFSET_WIDTH-1:0]                 r_off;
    logic                                    pop;

    assign o_valid      = (r_cnt != 3'd0);
    assign o_last       = (r_cnt == 3'd1);
    assign pop          = o_valid && i_m_ready;
    assign o_load_ready = (r_cnt == 3'd0) || (o_last && i_m_ready);
    assign o_byte       = r_bytes[0];
    assign o_status     = r_status;
    assign o_code       = r_code;
    assign o_offset     = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // load a beat's results, then shift the next byte of a run to the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes  <= i_res.bytes;
            r_status <= i_res.status;
            r_code   <= i_res.code;
            r_off    <= i_error_offset;
        end else if (pop) begin
            r_bytes  <= {8'h00, r_bytes[jsu_pkg::MAX_RESULTS-1:1]};
        end
    end

endmodule

// File: hdl/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// Timing: a result appears on the master side in the cycle after its beat is taken.
// Throughput: one beat per cycle while the buffer is free; a beat with n results
//   holds the slave side until its last result is taken, one per ready cycle.
// Reset: synchronous, active low; decoder returns to idle awaiting a quote and
//   the result buffer empties.
// ---------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Streaming decoder of one JSON string literal per run, with error reporting.
// ---------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 #(
    parameter int OFFSET_WIDTH = jsu_pkg::OFFSET_WIDTH_DEF,
    localparam int TDATA_W     = ((12 + OFFSET_WIDTH + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,  // in_byte
    input  logic                i_s_axis_tuser,  // text_end
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [TDATA_W-1:0]  o_m_axis_tdata,  // out_byte, error_code, error_offset
    output logic [1:0]          o_m_axis_tuser,  // status
    output logic                o_m_axis_tlast   // last_of_run
);

    logic                     accept;
    jsu_pkg::t_dec_res        dec_res;
    logic [OFFSET_WIDTH-1:0]  dec_off;
    logic [7:0]               out_byte;
    jsu_pkg::t_status         out_status;
    jsu_pkg::t_err            out_code;
    logic [OFFSET_WIDTH-1:0]  out_off;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    jsu_decode #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_s_axis_tdata),
        .i_text_end     (i_s_axis_tuser),
        .o_res          (dec_res),
        .o_error_offset (dec_off)
    );

    jsu_outbuf #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_outbuf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_res          (dec_res),
        .i_error_offset (dec_off),
        .i_m_ready      (i_m_axis_tready),
        .o_load_ready   (o_s_axis_tready),
        .o_valid        (o_m_axis_tvalid),
        .o_last         (o_m_axis_tlast),
        .o_byte         (out_byte),
        .o_status       (out_status),
        .o_code         (out_code),
        .o_offset       (out_off)
    );

    assign o_m_axis_tdata = TDATA_W'({out_off, out_code, out_byte});
    assign o_m_axis_tuser = out_status;

    `JSU_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready)
    `JSU_ASSERT_IMP(a_status_single, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser != jsu_pkg::ST_DATA, o_m_axis_tlast)
    `JSU_ASSERT_IMP(a_status_no_byte, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser != jsu_pkg::ST_DATA, o_m_axis_tdata[7:0] == 8'h00)
    `JSU_ASSERT_NXT(a_run_continues, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid)

endmodule
